// ----- hw/rtl/link_token_flow_control_core_macros.svh -----
// assertion macros for the link token flow control core
`ifndef LINK_TOKEN_FLOW_CONTROL_CORE_MACROS_SVH
`define LINK_TOKEN_FLOW_CONTROL_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define LFC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LFC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/lfc_pkg.sv -----
// types and constants of the link token flow control block
package lfc_pkg;

    localparam int MODE_W      = 2;
    localparam int KIND_W      = 2;
    localparam int FLITS_W     = 5;
    localparam int RX_RET_W    = 10;
    localparam int RET_W       = 10;
    localparam int GAP_W       = 11;
    localparam int FT_W        = 10;
    localparam int OUT_CNT_W   = 10;
    localparam int PROD_W      = FLITS_W + FT_W;
    localparam int FRAC_W      = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 10;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 48;

    localparam logic [FT_W-1:0] FT_RESET = FT_W'(16);

    // item kind on the input side
    typedef enum logic [MODE_W-1:0] {
        MODE_SEND    = 2'd0,
        MODE_RECV    = 2'd1,
        MODE_EXTRACT = 2'd2,
        MODE_IDLE    = 2'd3
    } t_mode;

    // what went out in a send slot
    typedef enum logic [KIND_W-1:0] {
        KIND_DATA   = 2'd0,
        KIND_RETURN = 2'd1,
        KIND_NULL   = 2'd2,
        KIND_NONE   = 2'd3
    } t_slot_kind;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOST_MODE = 1'd0,
        CFG_FLIT_TIME = 1'd1
    } t_cfg_reg;

    typedef struct packed {
        t_mode                mode;
        logic                 head_valid;
        logic [FLITS_W-1:0]   head_flits;
        logic [RX_RET_W-1:0]  rx_return_count;
        logic [FLITS_W-1:0]   extracted_flits;
    } t_in_item;

    typedef struct packed {
        t_slot_kind           slot_kind;
        logic                 pop_head;
        logic [RET_W-1:0]     return_count;
        logic [GAP_W-1:0]     slot_gap;
        logic [OUT_CNT_W-1:0] tokens_now;
        logic [OUT_CNT_W-1:0] unreturned_now;
    } t_result;

endpackage

// ----- hw/rtl/lfc_step_logic.sv -----
// slot decision, token return and counter update for one item
module lfc_step_logic import lfc_pkg::*; #(
    parameter int CNT_W = 10
) (
    input  logic             i_host_mode,
    input  logic [FT_W-1:0]  i_flit_time,
    input  logic [CNT_W-1:0] i_tokens,
    input  logic [CNT_W-1:0] i_unret,
    input  t_in_item         i_item,
    output t_result          o_result,
    output logic [CNT_W-1:0] o_tokens_nxt,
    output logic [CNT_W-1:0] o_unret_nxt
);

    localparam int CMP_W    = (CNT_W > FLITS_W) ? CNT_W : FLITS_W;
    localparam int EXT_SUM_W = CMP_W + 1;
    localparam int RX_SUM_W  = ((CNT_W > RX_RET_W) ? CNT_W : RX_RET_W) + 1;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    logic [CNT_W-1:0]     top_pow;
    logic                 data_ok;
    logic [CMP_W-1:0]     tok_left;
    logic [RX_SUM_W-1:0]  rx_sum;
    logic [EXT_SUM_W-1:0] ext_sum;
    logic [CNT_W-1:0]     tok_sat;
    logic [CNT_W-1:0]     unret_sat;
    logic [FLITS_W-1:0]   gap_flits;
    logic [PROD_W-1:0]    gap_prod;
    logic [PROD_W-1:0]    gap_round;
    logic [GAP_W-1:0]     gap_val;

    // highest set bit of the unreturned count
    always_comb begin
        top_pow = '0;
        for (int i = 0; i < CNT_W; i++) begin
            if (i_unret[i]) begin
                top_pow    = '0;
                top_pow[i] = 1'b1;
            end
        end
    end

    // data packet fits in the remaining tokens
    assign data_ok  = i_item.head_valid &&
                      (CMP_W'(i_tokens) >= CMP_W'(i_item.head_flits));
    assign tok_left = CMP_W'(i_tokens) - CMP_W'(i_item.head_flits);

    // saturating counter additions
    assign rx_sum    = RX_SUM_W'(i_tokens) + RX_SUM_W'(i_item.rx_return_count);
    assign tok_sat   = (rx_sum > RX_SUM_W'(CNT_MAX)) ? CNT_MAX : rx_sum[CNT_W-1:0];
    assign ext_sum   = EXT_SUM_W'(i_unret) + EXT_SUM_W'(i_item.extracted_flits);
    assign unret_sat = (ext_sum > EXT_SUM_W'(CNT_MAX)) ? CNT_MAX : ext_sum[CNT_W-1:0];

    // slot gap in whole cycles, rounded up from the q4 flit time
    assign gap_flits = data_ok ? i_item.head_flits : FLITS_W'(1);
    assign gap_prod  = PROD_W'(gap_flits) * PROD_W'(i_flit_time);
    assign gap_round = gap_prod + PROD_W'(15);
    assign gap_val   = GAP_W'(gap_round[PROD_W-1:FRAC_W]);

    // packet choice and next counters
    always_comb begin
        o_tokens_nxt          = i_tokens;
        o_unret_nxt           = i_unret;
        o_result.slot_kind    = KIND_NONE;
        o_result.pop_head     = 1'b0;
        o_result.return_count = '0;
        o_result.slot_gap     = '0;
        case (i_item.mode)
            MODE_SEND: begin
                if (data_ok) begin
                    o_result.slot_kind    = KIND_DATA;
                    o_result.pop_head     = 1'b1;
                    o_result.return_count = RET_W'(top_pow);
                    o_result.slot_gap     = gap_val;
                    o_unret_nxt           = i_unret - top_pow;
                    if (!i_host_mode) begin
                        o_tokens_nxt = tok_left[CNT_W-1:0];
                    end
                end else if (i_unret != '0) begin
                    o_result.slot_kind    = KIND_RETURN;
                    o_result.return_count = RET_W'(top_pow);
                    o_result.slot_gap     = i_host_mode ? gap_val : '0;
                    o_unret_nxt           = i_unret - top_pow;
                end else begin
                    o_result.slot_kind = KIND_NULL;
                    o_result.slot_gap  = gap_val;
                end
            end
            MODE_RECV:    o_tokens_nxt = tok_sat;
            MODE_EXTRACT: o_unret_nxt  = unret_sat;
            default:      ;
        endcase
        o_result.tokens_now     = OUT_CNT_W'(o_tokens_nxt);
        o_result.unreturned_now = OUT_CNT_W'(o_unret_nxt);
    end

endmodule

// ----- hw/rtl/link_token_flow_control_core.sv -----
// Link token flow control: credit counting with piggybacked token return.
// One item is taken every cycle while the result stream does not stall; the
// item is held in the input register and its result in the result register;
// slot decision and counter update are combinational between them, so the
// token counters are updated once per item in arrival order. Mode 0 items
// are send slots, mode 1 items credit received return tokens, mode 2 items
// count locally extracted flits, mode 3 is idle; every item gives exactly
// one result. Counters are COUNTER_WIDTH bits and saturate. Configuration
// writes take effect at once and are meant for idle periods.
module link_token_flow_control_core import lfc_pkg::*; #(
    parameter int COUNTER_WIDTH = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration: 0 host link mode, 1 flit time in q4 cycles
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    // input item stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // head_valid[0], head_flits[5:1], rx_return_count[15:6], extracted_flits[20:16]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // mode[1:0]
    input  logic [MODE_W-1:0]      s_axis_tuser,
    // result item stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // pop_head[0], return_count[10:1], slot_gap[21:11], tokens_now[31:22],
    // unreturned_now[41:32]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // slot_kind[1:0]
    output logic [KIND_W-1:0]      m_axis_tuser
);

    `include "link_token_flow_control_core_macros.svh"

    logic                     r_in_vld;
    t_in_item                 r_in;
    logic                     r_out_vld;
    t_result                  r_out;
    logic [COUNTER_WIDTH-1:0] r_tokens;
    logic [COUNTER_WIDTH-1:0] r_unret;
    logic                     r_host;
    logic [FT_W-1:0]          r_ft;

    t_in_item                 s_item;
    t_result                  w_result;
    logic [COUNTER_WIDTH-1:0] n_tokens;
    logic [COUNTER_WIDTH-1:0] n_unret;
    logic                     w_out_free;
    logic                     w_adv;

    // unpack the input item
    assign s_item.mode            = t_mode'(s_axis_tuser);
    assign s_item.head_valid      = s_axis_tdata[0];
    assign s_item.head_flits      = s_axis_tdata[5:1];
    assign s_item.rx_return_count = s_axis_tdata[15:6];
    assign s_item.extracted_flits = s_axis_tdata[20:16];

    // pipeline flow: result register frees up when taken
    assign w_out_free    = !r_out_vld || m_axis_tready;
    assign w_adv         = r_in_vld && w_out_free;
    assign s_axis_tready = i_rst_n && (!r_in_vld || w_adv);

    lfc_step_logic #(
        .CNT_W (COUNTER_WIDTH)
    ) u_step (
        .i_host_mode  (r_host),
        .i_flit_time  (r_ft),
        .i_tokens     (r_tokens),
        .i_unret      (r_unret),
        .i_item       (r_in),
        .o_result     (w_result),
        .o_tokens_nxt (n_tokens),
        .o_unret_nxt  (n_unret)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= s_item;
        end
    end

    // result register and counter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_tokens  <= '0;
            r_unret   <= '0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
            r_tokens  <= n_tokens;
            r_unret   <= n_unret;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_host <= 1'b0;
            r_ft   <= FT_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_HOST_MODE: r_host <= i_cfg_wdata[0];
                CFG_FLIT_TIME: r_ft   <= i_cfg_wdata[FT_W-1:0];
                default:       ;
            endcase
        end
    end

    // pack the result item
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out.slot_kind;
    assign m_axis_tdata  = {6'd0, r_out.unreturned_now, r_out.tokens_now,
                            r_out.slot_gap, r_out.return_count, r_out.pop_head};

    // checks
    `LFC_ASSERT_IMP(a_none_fields_zero,
        r_out_vld && r_out.slot_kind == KIND_NONE,
        !r_out.pop_head && r_out.return_count == '0 && r_out.slot_gap == '0,
        "no-slot result carries packet fields")
    `LFC_ASSERT_IMP(a_pop_only_data, r_out_vld,
        r_out.pop_head == (r_out.slot_kind == KIND_DATA),
        "pop_head disagrees with slot kind")
    `LFC_ASSERT_IMP(a_return_pow2, r_out_vld, $onehot0(r_out.return_count),
        "return count is not a power of two")
    `LFC_ASSERT_NXT(a_counters_hold, !w_adv,
        $stable(r_tokens) && $stable(r_unret),
        "counters changed without an item")
    `LFC_ASSERT_NXT(a_return_drains, w_adv && w_result.slot_kind == KIND_RETURN,
        r_unret < $past(r_unret),
        "token return left unreturned count unchanged")

endmodule
